@@ hdl/gsm_pkg.sv @@
// ----------------------------------------------------------------------------
// gsm_pkg: shared types for the generational slot map
// Request kinds, status codes and the response layout used by the unit and
// its port checker.
// ----------------------------------------------------------------------------
package gsm_pkg;

   localparam int HANDLE_IDX_W = 8;   // index field width on the ports
   localparam int HANDLE_GEN_W = 8;   // generation field width on the ports
   localparam int TOTAL_W      = 9;   // live_total width
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 48;

   typedef enum logic [2:0] {
      REQ_ALLOC    = 3'd0,
      REQ_ALLOC_ID = 3'd1,
      REQ_LOOKUP   = 3'd2,
      REQ_REMOVE   = 3'd3,
      REQ_CLEAR    = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_STALE     = 3'd1,
      STAT_RESERVED  = 3'd2,
      STAT_EXISTS    = 3'd3,
      STAT_FULL      = 3'd4,
      STAT_NOT_FRESH = 3'd5
   } status_type;

   // rsp tdata layout, lowest field last
   typedef struct packed {
      logic [5:0]              pad;
      logic [TOTAL_W-1:0]      live_total;
      logic [HANDLE_IDX_W-1:0] moved_index;
      logic                    moved_valid;
      logic [HANDLE_IDX_W-1:0] dense_position;
      logic [HANDLE_GEN_W-1:0] out_generation;
      logic [HANDLE_IDX_W-1:0] out_index;
   } rsp_payload_type;

   typedef struct packed {
      status_type      status;
      rsp_payload_type payload;
   } gsm_result_type;

endpackage

@@ hdl/generational_slot_map_unit.sv @@
// ----------------------------------------------------------------------------
// generational_slot_map_unit: generational handle allocator
// Hands out slot handles (index plus generation), keeps a packed list of
// live slots, and recycles removed slots through a free stack.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one request per transfer. tuser carries the request kind
//   (allocate, allocate with id, lookup, remove, clear), tdata the handle.
//   rsp channel: exactly one result per request, in request order. tuser
//   carries the status, tdata the handle, packed position, swap-and-pop
//   move and the live count after the request.
//   States per request: lookup passes through a check state; clear and a
//   request rejected at decode through an emit state; allocate from the
//   high-water mark through a place state; allocate from the free stack
//   through pop, then place; remove through check, then move. Allocate with
//   id below the mark goes through check; above it, the unit walks the skipped
//   slots, marking each dead in the slot memory, then places. The slot and
//   list memories have registered reads: each step reads, then writes back.
//   Reset empties the table at once (high-water mark, stack depth and live
//   count are registers); no memory sweep is needed, clear works the same.
//   The result sits in an output register; a stalled receiver holds it while
//   the next request is taken, and the unit waits only at its final step.
// ----------------------------------------------------------------------------
module generational_slot_map_unit
   import gsm_pkg::*;
#(
   parameter int SLOT_COUNT = 256,
   parameter int GEN_BITS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] entity_index, [15:8] entity_generation
   input  logic [2:0]            req_tuser,  // [2:0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] out_index, [15:8] out_generation, [23:16] dense_position,
   // [24] moved_valid, [32:25] moved_index, [41:33] live_total, [47:42] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser   // [2:0] status
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // slot memory word: liveness, generation and packed-list position
   typedef struct packed {
      logic                live;
      logic [GEN_BITS-1:0] gen;
      logic [IDX_W-1:0]    pos;
   } slot_word_type;

   localparam int SLOT_W = $bits(slot_word_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_PLACE,
      S_WALK,
      S_CHECK,
      S_MOVE,
      S_EMIT
   } state_type;

   state_type      state_ff, state_in;
   req_kind_type   kind_ff, kind_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [GEN_BITS-1:0] gen_ff, gen_in;
   logic [IDX_W-1:0]    walk_ff, walk_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    mover_ff, mover_in;
   logic                mem_gen_ff, mem_gen_in;
   logic [CNT_W-1:0]    hw_ff, hw_in;
   logic [CNT_W-1:0]    fd_ff, fd_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   gsm_result_type      res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gsm_result_type      rsp_data_ff, rsp_data_in;

   // memory ports
   logic                slot_wr_en, slot_rd_en;
   logic [IDX_W-1:0]    slot_wr_addr, slot_rd_addr;
   slot_word_type       slot_wr_data, slot_rd;
   logic [SLOT_W-1:0]   slot_rd_data;
   logic                list_wr_en, list_rd_en;
   logic [IDX_W-1:0]    list_wr_addr, list_rd_addr;
   logic [IDX_W-1:0]    list_wr_data, list_rd_data;

   // request decode
   req_kind_type        in_kind;
   logic [7:0]          in_index;
   logic [IDX_W-1:0]    in_slot;
   logic                in_range, below_hw;
   logic                out_free, hit;
   logic [IDX_W-1:0]    stack_top_addr, push_addr, last_slot;
   logic [GEN_BITS-1:0] place_gen;

   // placement and finish controls
   logic                place_go;
   logic [IDX_W-1:0]    place_idx;
   logic [GEN_BITS-1:0] place_g;
   logic                finish;
   gsm_result_type      fin_res;
   logic                moved;

   function automatic gsm_result_type status_only(status_type st, logic [CNT_W-1:0] live);
      gsm_result_type r;
      r = '0;
      r.status = st;
      r.payload.live_total = TOTAL_W'(live);
      return r;
   endfunction

   function automatic gsm_result_type ok_result(logic [IDX_W-1:0] idx,
                                                logic [GEN_BITS-1:0] g,
                                                logic [IDX_W-1:0] pos,
                                                logic [CNT_W-1:0] live);
      gsm_result_type r;
      r = status_only(STAT_OK, live);
      r.payload.out_index      = HANDLE_IDX_W'(idx);
      r.payload.out_generation = HANDLE_GEN_W'(g);
      r.payload.dense_position = HANDLE_IDX_W'(pos);
      return r;
   endfunction

   // slot table: liveness, generation, position
   gsm_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // packed live list grows up from entry zero, free stack grows down from
   // the top entry; live plus free slots never exceed the slot count
   gsm_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (IDX_W)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   assign slot_rd        = slot_rd_data;
   assign in_kind        = req_kind_type'(req_tuser);
   assign in_index       = req_tdata[7:0];
   assign in_slot        = IDX_W'(in_index);
   assign in_range       = 32'(in_index) < 32'(SLOT_COUNT);
   // slots at or above the high-water mark read as dead with generation zero
   assign below_hw       = 32'(in_index) < 32'(hw_ff);
   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign hit            = slot_rd.live && (slot_rd.gen == gen_ff);
   assign stack_top_addr = IDX_W'(CNT_W'(SLOT_COUNT) - fd_ff);
   assign push_addr      = IDX_W'(CNT_W'(SLOT_COUNT - 1) - fd_ff);
   assign last_slot      = IDX_W'(live_ff - CNT_W'(1));
   assign place_gen      = mem_gen_ff ? slot_rd.gen : gen_ff;
   assign moved          = slot_rd.pos != last_slot;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.payload;
   assign rsp_tuser  = rsp_data_ff.status;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      gen_in       = gen_ff;
      walk_in      = walk_ff;
      pos_in       = pos_ff;
      mover_in     = mover_ff;
      mem_gen_in   = mem_gen_ff;
      hw_in        = hw_ff;
      fd_in        = fd_ff;
      live_in      = live_ff;
      res_in       = res_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = idx_ff;
      slot_wr_data = '0;
      slot_rd_en   = 1'b0;
      slot_rd_addr = in_slot;
      list_wr_en   = 1'b0;
      list_wr_addr = IDX_W'(live_ff);
      list_wr_data = idx_ff;
      list_rd_en   = 1'b0;
      list_rd_addr = stack_top_addr;
      place_go     = 1'b0;
      place_idx    = idx_ff;
      place_g      = gen_ff;
      finish       = 1'b0;
      fin_res      = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in    = in_kind;
               idx_in     = in_slot;
               gen_in     = GEN_BITS'(req_tdata[15:8]);
               mem_gen_in = 1'b0;
               state_in   = S_EMIT;
               res_in     = status_only(STAT_STALE, live_ff);
               case (in_kind) inside
                  REQ_ALLOC: begin
                     if (fd_ff != '0) begin
                        // pop a recycled index
                        list_rd_en = 1'b1;
                        state_in   = S_POP;
                     end else if (hw_ff < CNT_W'(SLOT_COUNT)) begin
                        // take a never-used slot, generation starts at zero
                        idx_in   = IDX_W'(hw_ff);
                        gen_in   = '0;
                        hw_in    = hw_ff + CNT_W'(1);
                        state_in = S_PLACE;
                     end else begin
                        res_in = status_only(STAT_FULL, live_ff);
                     end
                  end
                  REQ_ALLOC_ID: begin
                     if (fd_ff != '0) begin
                        res_in = status_only(STAT_NOT_FRESH, live_ff);
                     end else if (in_index == '0) begin
                        res_in = status_only(STAT_RESERVED, live_ff);
                     end else if (!in_range) begin
                        res_in = status_only(STAT_FULL, live_ff);
                     end else if (below_hw) begin
                        slot_rd_en = 1'b1;
                        state_in   = S_CHECK;
                     end else begin
                        // grow the high-water mark; mark skipped slots dead
                        hw_in   = CNT_W'(in_slot) + CNT_W'(1);
                        walk_in = IDX_W'(hw_ff);
                        if (CNT_W'(in_slot) == hw_ff) begin
                           state_in = S_PLACE;
                        end else begin
                           state_in = S_WALK;
                        end
                     end
                  end
                  REQ_LOOKUP, REQ_REMOVE: begin
                     if (in_index != '0 && below_hw) begin
                        slot_rd_en   = 1'b1;
                        list_rd_en   = 1'b1;
                        list_rd_addr = last_slot;
                        state_in     = S_CHECK;
                     end
                  end
                  REQ_CLEAR: begin
                     hw_in   = CNT_W'(1);
                     fd_in   = '0;
                     live_in = '0;
                     res_in  = status_only(STAT_OK, '0);
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_POP: begin
            idx_in       = list_rd_data;
            slot_rd_en   = 1'b1;
            slot_rd_addr = list_rd_data;
            mem_gen_in   = 1'b1;
            fd_in        = fd_ff - CNT_W'(1);
            state_in     = S_PLACE;
         end

         S_WALK: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = walk_ff;
            slot_wr_data = '0;
            walk_in      = walk_ff + IDX_W'(1);
            if (walk_in == idx_ff) begin
               state_in = S_PLACE;
            end
         end

         S_PLACE: begin
            place_go = out_free;
            place_g  = place_gen;
         end

         S_CHECK: begin
            case (kind_ff)
               REQ_ALLOC_ID: begin
                  if (slot_rd.live) begin
                     finish  = out_free;
                     fin_res = status_only(STAT_EXISTS, live_ff);
                  end else begin
                     place_go = out_free;
                  end
               end
               REQ_LOOKUP: begin
                  finish = out_free;
                  if (hit) begin
                     fin_res = ok_result(idx_ff, slot_rd.gen, slot_rd.pos, live_ff);
                  end else begin
                     fin_res = status_only(STAT_STALE, live_ff);
                  end
               end
               REQ_REMOVE: begin
                  if (!hit) begin
                     finish  = out_free;
                     fin_res = status_only(STAT_STALE, live_ff);
                  end else begin
                     // retire the slot and bump its generation
                     slot_wr_en   = 1'b1;
                     slot_wr_addr = idx_ff;
                     slot_wr_data = '{live: 1'b0, gen: slot_rd.gen + GEN_BITS'(1),
                                      pos: slot_rd.pos};
                     // swap-and-pop: last packed entry fills the gap
                     if (moved) begin
                        list_wr_en   = 1'b1;
                        list_wr_addr = slot_rd.pos;
                        list_wr_data = list_rd_data;
                        slot_rd_en   = 1'b1;
                        slot_rd_addr = list_rd_data;
                     end
                     pos_in   = slot_rd.pos;
                     mover_in = list_rd_data;
                     live_in  = live_ff - CNT_W'(1);
                     res_in   = ok_result(idx_ff, slot_rd.gen, slot_rd.pos,
                                          live_ff - CNT_W'(1));
                     res_in.payload.moved_valid = moved;
                     res_in.payload.moved_index = moved ? HANDLE_IDX_W'(list_rd_data) : '0;
                     state_in = S_MOVE;
                  end
               end
               default: begin
                  finish  = out_free;
                  fin_res = status_only(STAT_STALE, live_ff);
               end
            endcase
         end

         S_MOVE: begin
            if (out_free) begin
               finish  = 1'b1;
               fin_res = res_ff;
               if (res_ff.payload.moved_valid) begin
                  slot_wr_en   = 1'b1;
                  slot_wr_addr = mover_ff;
                  slot_wr_data = '{live: slot_rd.live, gen: slot_rd.gen, pos: pos_ff};
               end
               // push the freed index; the stack cannot overflow
               list_wr_en   = 1'b1;
               list_wr_addr = push_addr;
               list_wr_data = idx_ff;
               fd_in        = fd_ff + CNT_W'(1);
            end
         end

         S_EMIT: begin
            finish  = out_free;
            fin_res = res_ff;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // append a slot to the packed list and report it
      if (place_go) begin
         slot_wr_en   = 1'b1;
         slot_wr_addr = place_idx;
         slot_wr_data = '{live: 1'b1, gen: place_g, pos: IDX_W'(live_ff)};
         list_wr_en   = 1'b1;
         list_wr_addr = IDX_W'(live_ff);
         list_wr_data = place_idx;
         live_in      = live_ff + CNT_W'(1);
         finish       = 1'b1;
         fin_res      = ok_result(place_idx, place_g, IDX_W'(live_ff),
                                  live_ff + CNT_W'(1));
      end

      if (finish) begin
         state_in = S_IDLE;
      end

      // output register: load on finish, drop once the transfer completes
      rsp_data_in = finish ? fin_res : rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hw_ff        <= CNT_W'(1);
         fd_ff        <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         fd_ff        <= fd_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      gen_ff      <= gen_in;
      walk_ff     <= walk_in;
      pos_ff      <= pos_in;
      mover_ff    <= mover_in;
      mem_gen_ff  <= mem_gen_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hdl/gsm_ram.sv @@
// ----------------------------------------------------------------------------
// gsm_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds
// between enabled reads. Contents are undefined until written.
// ----------------------------------------------------------------------------
module gsm_ram
   import gsm_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/gsm_checker.sv @@
// ----------------------------------------------------------------------------
// gsm_checker: port-level checks for the generational slot map
// Watches the request and result channels of the unit; bound to the unit.
// ----------------------------------------------------------------------------
module gsm_checker
   import gsm_pkg::*;
#(
   parameter int SLOT_COUNT = 256
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [2:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]            rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   // a rejected request carries no handle, position or move
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata[32:0] == '0)
      else $error("non-ok result carries handle fields");

   // a swap-and-pop move only comes with a successful remove
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |-> rsp_tuser == STAT_OK)
      else $error("move reported on a failed request");

   // slot zero is reserved, so the live count stays below the slot count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[41:33]) < 32'(SLOT_COUNT))
      else $error("live count out of range");

endmodule

bind generational_slot_map_unit gsm_checker #(.SLOT_COUNT(SLOT_COUNT)) u_gsm_checker (.*);
